@@ rtl/core/hbt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbt_pkg
// Shared types and codes for the heartbeat timeout table: command classes,
// result status codes and the entry that moves from front end to back end.
// ----------------------------------------------------------------------------
package hbt_pkg;

  // command codes as they arrive on the input channel
  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_BEAT     = 2'd1;
  localparam logic [1:0] CMD_CHECK    = 2'd2;
  localparam logic [1:0] CMD_QUERY    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
  localparam logic [1:0] ST_TIMEOUT    = 2'd3;

  // decoded operation class
  typedef enum logic [1:0] {
    OP_REGISTER,
    OP_BEAT,
    OP_CHECK,
    OP_QUERY
  } op_t;

  // classified transaction queued between front and back
  typedef struct packed {
    op_t         op;
    logic [4:0]  handle;
    logic        out_of_range;
    logic [31:0] now_time;
    logic [31:0] timeout;
  } entry_t;

endpackage

@@ rtl/core/heartbeat_timeout_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_timeout_table
// Online-detection table: register, heartbeat, timeout check and query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one transaction carries a command, a slot handle, the
//   current tick count and a timeout. Output channel out_*: exactly one result
//   per transaction with status, slot, online bit, bitmap and used count.
//   Both channels move a transaction on a clock edge with valid high and
//   stall low.
//   Path: a transaction passes the input register, then the queue, then the
//   execute register, from which its result is taken.
//   Throughput: one transaction per cycle while out_stall is low; the stamp
//   table and bitmap do a single read-modify-write per cycle in the back end,
//   so consecutive heartbeats and checks on the same slot follow each other
//   directly. When the receiver stalls, the result register holds, the
//   two-entry queue fills, then the input register fills and in_stall rises.
//   Reset clears the bitmap, the slot count and all valid flags; stamps are
//   only read for slots that a register command has already written.
// ----------------------------------------------------------------------------
module heartbeat_timeout_table import hbt_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_handle,
  input  logic [31:0] in_now_time,
  input  logic [31:0] in_timeout,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot,
  output logic        out_online,
  output logic [15:0] out_online_map,
  output logic [4:0]  out_used_count
);

  logic   push, push_full, pop, not_empty;
  entry_t push_entry, pop_entry;

  // decode and hold incoming transactions
  hbt_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_handle  (in_handle),
    .in_now_time(in_now_time),
    .in_timeout (in_timeout),
    .push       (push),
    .push_full  (push_full),
    .push_entry (push_entry)
  );

  // decoupling queue
  hbt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (push_full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_entry (pop_entry)
  );

  // table update and result register
  hbt_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .not_empty     (not_empty),
    .pop_entry     (pop_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_online    (out_online),
    .out_online_map(out_online_map),
    .out_used_count(out_used_count)
  );

endmodule

@@ rtl/core/hbt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbt_front
// Input stage: takes a transaction, decodes the command, flags handles that
// lie beyond the table size and holds the entry until the queue takes it.
// ----------------------------------------------------------------------------
module hbt_front import hbt_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_handle,
  input  logic [31:0] in_now_time,
  input  logic [31:0] in_timeout,
  output logic        push,
  input  logic        push_full,
  output entry_t      push_entry
);

  logic   valid_r, valid_nxt;
  entry_t entry_r;
  entry_t entry_nxt;
  logic   accept;

  // stall only while a held entry cannot move on
  assign in_stall = valid_r && push_full;
  assign accept   = in_valid && !in_stall;
  assign push     = valid_r && !push_full;

  // command decode and static handle range check
  always_comb begin
    entry_nxt.handle       = in_handle;
    entry_nxt.now_time     = in_now_time;
    entry_nxt.timeout      = in_timeout;
    entry_nxt.out_of_range = ({1'b0, in_handle} >= 6'(MAX_SLOTS));
    case (in_command)
      CMD_REGISTER: entry_nxt.op = OP_REGISTER;
      CMD_BEAT:     entry_nxt.op = OP_BEAT;
      CMD_CHECK:    entry_nxt.op = OP_CHECK;
      CMD_QUERY:    entry_nxt.op = OP_QUERY;
      default:      entry_nxt.op = OP_QUERY;
    endcase
  end

  // holding register occupancy
  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
    end
  end

  assign push_entry = entry_r;

endmodule

@@ rtl/core/hbt_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbt_fifo
// Two-entry queue of classified transactions between front and back end.
// ----------------------------------------------------------------------------
module hbt_fifo import hbt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t pop_entry
);

  entry_t     slots_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_entry = slots_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/core/hbt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbt_back
// Execution stage: owns the stamp table, online bitmap and slot count, does
// one read-modify-write per transaction and registers the result.
// ----------------------------------------------------------------------------
module hbt_back import hbt_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        not_empty,
  input  entry_t      pop_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot,
  output logic        out_online,
  output logic [15:0] out_online_map,
  output logic [4:0]  out_used_count
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  logic [31:0]          last_seen_r [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] online_r, online_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           status_nxt, status_r;
  logic [3:0]           slot_nxt, slot_r;
  logic                 online_bit_nxt, online_bit_r;
  logic [15:0]          map_r;
  logic [4:0]           used_r;

  logic                 table_full;
  logic                 bad_handle;
  logic [IDX_W-1:0]     idx;
  logic [MAX_SLOTS-1:0] idx_hot;
  logic [31:0]          elapsed;
  logic                 stamp_we;
  logic [31:0]          map_ext;

  // take the next entry when the result register is free or draining
  assign pop = not_empty && (!out_valid_r || !out_stall);

  assign table_full = (6'(count_r) == 6'(MAX_SLOTS));
  assign bad_handle = pop_entry.out_of_range ||
                      ({1'b0, pop_entry.handle} >= 6'(count_r));

  // slot addressed by this transaction
  always_comb begin
    if (pop_entry.op == OP_REGISTER) begin
      idx = count_r[IDX_W-1:0];
    end else begin
      idx = pop_entry.handle[IDX_W-1:0];
    end
    idx_hot      = '0;
    idx_hot[idx] = 1'b1;
  end

  // wrapping elapsed time since the last stamp
  assign elapsed = pop_entry.now_time - last_seen_r[idx];

  // command execution
  always_comb begin
    count_nxt      = count_r;
    online_nxt     = online_r;
    stamp_we       = 1'b0;
    status_nxt     = ST_OK;
    slot_nxt       = pop_entry.handle[3:0];
    online_bit_nxt = 1'b0;
    case (pop_entry.op)
      OP_REGISTER: begin
        slot_nxt = 4'd0;
        if (table_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt      = count_r + CNT_W'(1);
          stamp_we       = 1'b1;
          online_nxt     = online_r | idx_hot;
          slot_nxt       = 4'(count_r);
          online_bit_nxt = 1'b1;
        end
      end
      OP_BEAT: begin
        if (bad_handle) begin
          status_nxt = ST_BAD_HANDLE;
        end else begin
          stamp_we       = 1'b1;
          online_nxt     = online_r | idx_hot;
          online_bit_nxt = 1'b1;
        end
      end
      OP_CHECK: begin
        if (bad_handle) begin
          status_nxt = ST_BAD_HANDLE;
        end else if (elapsed > pop_entry.timeout) begin
          online_nxt = online_r & ~idx_hot;
          status_nxt = ST_TIMEOUT;
        end else begin
          online_nxt     = online_r | idx_hot;
          online_bit_nxt = 1'b1;
        end
      end
      OP_QUERY: begin
        if (bad_handle) begin
          status_nxt = ST_BAD_HANDLE;
        end else begin
          online_bit_nxt = online_r[idx];
        end
      end
      default: begin
        status_nxt = ST_BAD_HANDLE;
      end
    endcase
  end

  assign map_ext = 32'(online_nxt);

  // result register occupancy
  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        online_r <= online_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  // stamp table
  always_ff @(posedge clk) begin
    if (pop && stamp_we) begin
      last_seen_r[idx] <= pop_entry.now_time;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      status_r     <= status_nxt;
      slot_r       <= slot_nxt;
      online_bit_r <= online_bit_nxt;
      map_r        <= map_ext[15:0];
      used_r       <= 5'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_slot       = slot_r;
  assign out_online     = online_bit_r;
  assign out_online_map = map_r;
  assign out_used_count = used_r;

endmodule

@@ rtl/core/hbt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbt_checker
// Port-level checks for the heartbeat timeout table, bound to the top level.
// ----------------------------------------------------------------------------
module hbt_checker import hbt_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [3:0]  out_slot,
  input logic        out_online,
  input logic [15:0] out_online_map,
  input logic [4:0]  out_used_count
);

  // a stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_slot) &&
      $stable(out_online) && $stable(out_online_map) && $stable(out_used_count))
    else $error("result payload changed while stalled");

  // slot count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 6'(out_used_count) <= 6'(MAX_SLOTS))
    else $error("used count beyond table size");

  // failed commands never report an online slot
  a_fail_offline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_BAD_HANDLE ||
      out_status == ST_TIMEOUT) |-> !out_online)
    else $error("online bit set on failed command");

  // a full table answers with slot zero and a full count
  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_slot == 4'd0 && out_used_count == 5'(MAX_SLOTS))
    else $error("table full result inconsistent");

endmodule

bind heartbeat_timeout_table hbt_checker #(.MAX_SLOTS(MAX_SLOTS)) u_hbt_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heartbeat timeout table. A directed table fills
// the slots, hits the full table, bad handles, wrapping time and the timeout
// boundary. Random heartbeat, check and query traffic follows, with random
// idle cycles on both channels and long output holds that back up the input.
// Each result is checked against its table row or an in-bench model of the slot table.
// ----------------------------------------------------------------------------
module tb;
  import hbt_pkg::*;

  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASE_LEN    = RANDOM_ITEMS / 4;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic        online;
    logic [15:0] map;
    logic [4:0]  count;
  } hb_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [4:0]  handle;
    logic [31:0] now;
    logic [31:0] tmo;
    int          reps;
    bit          typed;
    hb_result_t  res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [4:0]  in_handle;
  logic [31:0] in_now_time;
  logic [31:0] in_timeout;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [3:0]  out_slot;
  logic        out_online;
  logic [15:0] out_online_map;
  logic [4:0]  out_used_count;

  // expected results in order, and the model's copy of the slot table
  hb_result_t  pending_results[$];
  stim_row_t   stim_rows[$];
  logic [31:0] stamp_mem [SLOTS];
  logic [15:0] live_map;
  logic [4:0]  reg_count;
  int          mismatches;
  bit          send_idle;
  bit          recv_idle;

  heartbeat_timeout_table #(
    .MAX_SLOTS(SLOTS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_handle      (in_handle),
    .in_now_time    (in_now_time),
    .in_timeout     (in_timeout),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_online     (out_online),
    .out_online_map (out_online_map),
    .out_used_count (out_used_count)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #2_000_000;
    $display("heartbeat_timeout_table: mismatch");
    $finish;
  end

  // slot table model: applies one command and returns its result
  function automatic hb_result_t table_step(input logic [1:0] cmd, input logic [4:0] h,
                                            input logic [31:0] now, input logic [31:0] tmo);
    hb_result_t  r;
    logic [31:0] elapsed;
    r = '0;
    if (cmd == CMD_REGISTER) begin
      if (reg_count >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        stamp_mem[reg_count[3:0]] = now;
        live_map[reg_count[3:0]]  = 1'b1;
        r.status  = ST_OK;
        r.slot    = reg_count[3:0];
        r.online  = 1'b1;
        reg_count = reg_count + 5'd1;
      end
    end else if (h >= reg_count) begin
      r.status = ST_BAD_HANDLE;
      r.slot   = h[3:0];
    end else begin
      r.slot = h[3:0];
      case (cmd)
        CMD_BEAT: begin
          stamp_mem[h[3:0]] = now;
          live_map[h[3:0]]  = 1'b1;
          r.status = ST_OK;
          r.online = 1'b1;
        end
        CMD_CHECK: begin
          elapsed = now - stamp_mem[h[3:0]];
          // equal to the timeout still counts as alive
          if (elapsed > tmo) begin
            live_map[h[3:0]] = 1'b0;
            r.status = ST_TIMEOUT;
            r.online = 1'b0;
          end else begin
            live_map[h[3:0]] = 1'b1;
            r.status = ST_OK;
            r.online = 1'b1;
          end
        end
        default: begin
          r.status = ST_OK;
          r.online = live_map[h[3:0]];
        end
      endcase
    end
    r.map   = live_map;
    r.count = reg_count;
    return r;
  endfunction

  task automatic table_row(input logic [1:0] cmd, input logic [4:0] h, input logic [31:0] now,
                           input logic [31:0] tmo, input int reps, input bit typed,
                           input logic [1:0] st, input logic [3:0] sl, input logic onl,
                           input logic [15:0] map, input logic [4:0] cnt);
    stim_row_t row;
    row.cmd    = cmd;
    row.handle = h;
    row.now    = now;
    row.tmo    = tmo;
    row.reps   = reps;
    row.typed  = typed;
    row.res    = '{st, sl, onl, map, cnt};
    stim_rows.push_back(row);
  endtask

  // offer one transaction, wait for it to be taken, then record its result
  task automatic send_event(input logic [1:0] cmd, input logic [4:0] h, input logic [31:0] now,
                            input logic [31:0] tmo, input bit typed, input hb_result_t typed_res);
    int         gap;
    hb_result_t predicted;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_handle   <= h;
    in_now_time <= now;
    in_timeout  <= tmo;
    do @(posedge clk); while (in_stall);
    predicted = table_step(cmd, h, now, tmo);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // stimulus: reset, directed table, then random traffic in four idle phases
  initial begin : stimulus
    logic [1:0]  cmd;
    logic [4:0]  h;
    logic [31:0] now;
    logic [31:0] tmo;
    logic [31:0] tick_now;
    logic [31:0] elapsed;
    int          pick;
    int          phase;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = CMD_QUERY;
    in_handle   = '0;
    in_now_time = '0;
    in_timeout  = '0;
    live_map    = '0;
    reg_count   = '0;
    mismatches  = 0;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;
    foreach (stamp_mem[i]) stamp_mem[i] = '0;

    // empty table, wrap of the time counter, timeout boundary, full table
    table_row(CMD_QUERY,    0,  32'h0,         32'h0,         1, 1,
              ST_BAD_HANDLE, 0,  0, 16'h0000, 0);
    table_row(CMD_BEAT,     31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1,
              ST_BAD_HANDLE, 15, 0, 16'h0000, 0);
    table_row(CMD_CHECK,    5,  32'h0,         32'h0,         1, 1,
              ST_BAD_HANDLE, 5,  0, 16'h0000, 0);
    table_row(CMD_REGISTER, 31, 32'hFFFF_FFF0, 32'h0,         1, 1,
              ST_OK,         0,  1, 16'h0001, 1);
    table_row(CMD_CHECK,    0,  32'h0000_000F, 32'h0000_001F, 1, 1,
              ST_OK,         0,  1, 16'h0001, 1);
    table_row(CMD_CHECK,    0,  32'h0000_0010, 32'h0000_001F, 1, 1,
              ST_TIMEOUT,    0,  0, 16'h0000, 1);
    table_row(CMD_QUERY,    0,  32'h0,         32'h0,         1, 1,
              ST_OK,         0,  0, 16'h0000, 1);
    table_row(CMD_BEAT,     0,  32'hFFFF_FFFF, 32'h0,         1, 1,
              ST_OK,         0,  1, 16'h0001, 1);
    table_row(CMD_CHECK,    0,  32'h0,         32'h0,         1, 1,
              ST_TIMEOUT,    0,  0, 16'h0000, 1);
    table_row(CMD_CHECK,    0,  32'h5,         32'hFFFF_FFFF, 1, 1,
              ST_OK,         0,  1, 16'h0001, 1);
    table_row(CMD_QUERY,    1,  32'h0,         32'h0,         1, 1,
              ST_BAD_HANDLE, 1,  0, 16'h0001, 1);
    table_row(CMD_REGISTER, 0,  32'h8000_0000, 32'h0,         15, 0,
              ST_OK,         0,  0, 16'h0000, 0);
    table_row(CMD_REGISTER, 0,  32'h0,         32'h0,         1, 1,
              ST_FULL,       0,  0, 16'hFFFF, 16);
    table_row(CMD_CHECK,    15, 32'h0,         32'h7FFF_FFFF, 1, 1,
              ST_TIMEOUT,    15, 0, 16'h7FFF, 16);
    table_row(CMD_BEAT,     15, 32'hFFFF_FFFF, 32'h0,         1, 0,
              ST_OK,         0,  0, 16'h0000, 0);
    table_row(CMD_CHECK,    15, 32'hFFFF_FFFF, 32'h0,         1, 0,
              ST_OK,         0,  0, 16'h0000, 0);
    table_row(CMD_QUERY,    16, 32'h0,         32'h0,         1, 1,
              ST_BAD_HANDLE, 0,  0, 16'hFFFF, 16);
    table_row(CMD_QUERY,    31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1,
              ST_BAD_HANDLE, 15, 0, 16'hFFFF, 16);
    table_row(CMD_CHECK,    16, 32'h1234_5678, 32'h0,         1, 1,
              ST_BAD_HANDLE, 0,  0, 16'hFFFF, 16);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      for (int k = 0; k < stim_rows[i].reps; k++) begin
        send_event(stim_rows[i].cmd, stim_rows[i].handle, stim_rows[i].now,
                   stim_rows[i].tmo, stim_rows[i].typed, stim_rows[i].res);
      end
    end

    // random traffic: mostly valid handles on a moving clock, some noise
    tick_now = 32'hFFFF_F000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase     = n / PHASE_LEN;
      send_idle = (phase == 0) || (phase == 2);
      recv_idle = (phase == 0) || (phase == 3);
      pick      = $urandom_range(0, 99);
      tmo       = $urandom;
      tick_now  = tick_now + $urandom_range(0, 1500);
      if ($urandom_range(0, 49) == 0) tick_now = $urandom;
      now = tick_now;
      if (pick < 5) begin
        cmd = CMD_REGISTER;
        h   = 5'($urandom_range(0, 31));
      end else if (pick < 12) begin
        cmd = 2'($urandom_range(0, 3));
        h   = 5'($urandom_range(0, 31));
        now = $urandom;
      end else begin
        cmd = (pick < 40) ? CMD_BEAT : ((pick < 80) ? CMD_CHECK : CMD_QUERY);
        if (reg_count == 0 || $urandom_range(0, 9) == 0) h = 5'($urandom_range(reg_count, 31));
        else h = 5'($urandom_range(0, reg_count - 1));
        // aim the timeout at the elapsed time to hit both sides of the edge
        if (cmd == CMD_CHECK && h < reg_count) begin
          elapsed = now - stamp_mem[h[3:0]];
          case ($urandom_range(0, 4))
            0: tmo = elapsed - 32'd1;
            1: tmo = elapsed;
            2: tmo = elapsed + 32'd1;
            3: tmo = $urandom_range(0, 3000);
            default: ;
          endcase
        end
      end
      send_event(cmd, h, now, tmo, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain and allow for the pipeline depth
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("heartbeat_timeout_table: match");
    end else begin
      $display("heartbeat_timeout_table: mismatch");
    end
    $finish;
  end

  // result side back-pressure, with two long holds to fill the pipeline
  initial begin : result_sink
    int wait_cycles;
    int taken;
    out_stall = 1'b0;
    taken     = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken == 300 || taken == 700) wait_cycles = 60;
      else wait_cycles = recv_idle ? $urandom_range(0, 5) : 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    hb_result_t seen;
    hb_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_status, out_slot, out_online, out_online_map, out_used_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d slot=%0d online=%0d map=%h count=%0d",
                   seen.status, seen.slot, seen.online, seen.map, seen.count);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result error: expected status=%0d slot=%0d online=%0d map=%h count=%0d",
                     want.status, want.slot, want.online, want.map, want.count);
            $display("              actual   status=%0d slot=%0d online=%0d map=%h count=%0d",
                     seen.status, seen.slot, seen.online, seen.map, seen.count);
          end
        end
      end
    end
  end

endmodule
